>>> rtl/core/mieu_pkg.sv
// Shared types, constants and codes of the integer execute unit.
`timescale 1ns / 1ps

package mieu_pkg;

  localparam int DATA_W      = 32;
  localparam int NUM_REGS    = 32;
  localparam int REG_IDX_W   = $clog2(NUM_REGS);
  localparam int FUNC_W      = 5;
  localparam int SHAMT_W     = 5;
  localparam int IMM_W       = 16;
  localparam int TARGET_W    = 27;
  localparam int PC_KEEP_W   = DATA_W - TARGET_W;
  localparam int IMM_SHIFT   = 16;
  localparam logic [REG_IDX_W-1:0] LINK_REG = REG_IDX_W'(31);

  localparam int QUEUE_DEPTH   = 4;
  localparam int QPTR_W        = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);
  // Queue slots plus the execute stage plus the result register.
  localparam int IN_FLIGHT_MAX = QUEUE_DEPTH + 2;

  typedef enum logic [FUNC_W-1:0] {
    F_ADD   = 5'd0,
    F_SUB   = 5'd1,
    F_SLT   = 5'd2,
    F_SLTU  = 5'd3,
    F_AND   = 5'd4,
    F_OR    = 5'd5,
    F_XOR   = 5'd6,
    F_NOR   = 5'd7,
    F_SLLV  = 5'd8,
    F_SRLV  = 5'd9,
    F_SRAV  = 5'd10,
    F_SLL   = 5'd11,
    F_SRL   = 5'd12,
    F_SRA   = 5'd13,
    F_ADDI  = 5'd14,
    F_SLTI  = 5'd15,
    F_SLTIU = 5'd16,
    F_ANDI  = 5'd17,
    F_ORI   = 5'd18,
    F_XORI  = 5'd19,
    F_LUI   = 5'd20,
    F_J     = 5'd21,
    F_JAL   = 5'd22
  } func_t;

  typedef enum logic [3:0] {
    OP_ADD,
    OP_SUB,
    OP_SLT,
    OP_SLTU,
    OP_AND,
    OP_OR,
    OP_XOR,
    OP_NOR,
    OP_SLL,
    OP_SRL,
    OP_SRA,
    OP_PASS_B,
    OP_J,
    OP_JAL,
    OP_NOP
  } op_t;

  typedef struct packed {
    op_t                  op;
    logic                 wr_en;
    logic [REG_IDX_W-1:0] dest;
    logic [REG_IDX_W-1:0] src_a;
    logic [REG_IDX_W-1:0] src_b;
    logic [SHAMT_W-1:0]   shamt;
    logic                 use_imm;
    logic                 use_shamt;
    logic [DATA_W-1:0]    imm;
    logic [TARGET_W-1:0]  target;
  } q_entry_t;

  typedef struct packed {
    logic empty;
    logic full;
  } q_status_t;

  typedef struct packed {
    logic                 reg_written;
    logic [REG_IDX_W-1:0] written_index;
    logic [DATA_W-1:0]    written_value;
    logic [DATA_W-1:0]    pc_value;
  } result_t;

endpackage

>>> rtl/core/mieu_channels_if.sv
// Valid/ready channel interfaces for instructions in and results out.
`timescale 1ns / 1ps

interface mieu_in_if;
  logic                                valid;
  logic                                ready;
  logic [mieu_pkg::FUNC_W-1:0]         func;
  logic [mieu_pkg::REG_IDX_W-1:0]      dest_reg;
  logic [mieu_pkg::REG_IDX_W-1:0]      src_a_reg;
  logic [mieu_pkg::REG_IDX_W-1:0]      src_b_reg;
  logic [mieu_pkg::SHAMT_W-1:0]        shift_amount;
  logic [mieu_pkg::IMM_W-1:0]          immediate;
  logic [mieu_pkg::TARGET_W-1:0]       jump_target;

  modport source (
    output valid, func, dest_reg, src_a_reg, src_b_reg, shift_amount, immediate,
           jump_target,
    input  ready
  );
  modport sink (
    input  valid, func, dest_reg, src_a_reg, src_b_reg, shift_amount, immediate,
           jump_target,
    output ready
  );
endinterface

interface mieu_out_if;
  logic                                valid;
  logic                                ready;
  logic                                reg_written;
  logic [mieu_pkg::REG_IDX_W-1:0]      written_index;
  logic [mieu_pkg::DATA_W-1:0]         written_value;
  logic [mieu_pkg::DATA_W-1:0]         pc_value;

  modport source (
    output valid, reg_written, written_index, written_value, pc_value,
    input  ready
  );
  modport sink (
    input  valid, reg_written, written_index, written_value, pc_value,
    output ready
  );
endinterface

>>> rtl/core/mieu_ram.sv
// Generic RAM with one write port and two registered read ports.
`timescale 1ns / 1ps

module mieu_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_a_r;
  logic [WIDTH-1:0] rdata_b_r;

  // Reads return the contents held before a write at the same edge.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_a_r <= mem_r[raddr_a];
      rdata_b_r <= mem_r[raddr_b];
    end
  end

  assign rdata_a = rdata_a_r;
  assign rdata_b = rdata_b_r;

endmodule

>>> rtl/core/mieu_front.sv
// Front end: accepts instructions and classifies them into queue entries.
`timescale 1ns / 1ps

module mieu_front (
  mieu_in_if.sink              in_ch,
  input  mieu_pkg::q_status_t  q_status,
  output logic                 push,
  output mieu_pkg::q_entry_t   entry
);

  logic [mieu_pkg::DATA_W-1:0] imm_sext;
  logic [mieu_pkg::DATA_W-1:0] imm_zext;
  logic [mieu_pkg::DATA_W-1:0] imm_upper;
  logic                        writes;

  assign in_ch.ready = !q_status.full;
  assign push        = in_ch.valid && in_ch.ready;

  assign imm_sext  = {{(mieu_pkg::DATA_W - mieu_pkg::IMM_W){in_ch.immediate[mieu_pkg::IMM_W-1]}},
                      in_ch.immediate};
  assign imm_zext  = {{(mieu_pkg::DATA_W - mieu_pkg::IMM_W){1'b0}}, in_ch.immediate};
  assign imm_upper = {in_ch.immediate, {mieu_pkg::IMM_SHIFT{1'b0}}};

  always_comb begin
    entry.op        = mieu_pkg::OP_NOP;
    entry.dest      = in_ch.dest_reg;
    entry.src_a     = in_ch.src_a_reg;
    entry.src_b     = in_ch.src_b_reg;
    entry.shamt     = in_ch.shift_amount;
    entry.use_imm   = 1'b0;
    entry.use_shamt = 1'b0;
    entry.imm       = imm_sext;
    entry.target    = in_ch.jump_target;
    writes          = 1'b1;
    case (mieu_pkg::func_t'(in_ch.func))
      mieu_pkg::F_ADD:  entry.op = mieu_pkg::OP_ADD;
      mieu_pkg::F_SUB:  entry.op = mieu_pkg::OP_SUB;
      mieu_pkg::F_SLT:  entry.op = mieu_pkg::OP_SLT;
      mieu_pkg::F_SLTU: entry.op = mieu_pkg::OP_SLTU;
      mieu_pkg::F_AND:  entry.op = mieu_pkg::OP_AND;
      mieu_pkg::F_OR:   entry.op = mieu_pkg::OP_OR;
      mieu_pkg::F_XOR:  entry.op = mieu_pkg::OP_XOR;
      mieu_pkg::F_NOR:  entry.op = mieu_pkg::OP_NOR;
      mieu_pkg::F_SLLV: entry.op = mieu_pkg::OP_SLL;
      mieu_pkg::F_SRLV: entry.op = mieu_pkg::OP_SRL;
      mieu_pkg::F_SRAV: entry.op = mieu_pkg::OP_SRA;
      mieu_pkg::F_SLL: begin
        entry.op        = mieu_pkg::OP_SLL;
        entry.use_shamt = 1'b1;
      end
      mieu_pkg::F_SRL: begin
        entry.op        = mieu_pkg::OP_SRL;
        entry.use_shamt = 1'b1;
      end
      mieu_pkg::F_SRA: begin
        entry.op        = mieu_pkg::OP_SRA;
        entry.use_shamt = 1'b1;
      end
      mieu_pkg::F_ADDI: begin
        entry.op      = mieu_pkg::OP_ADD;
        entry.use_imm = 1'b1;
      end
      mieu_pkg::F_SLTI: begin
        entry.op      = mieu_pkg::OP_SLT;
        entry.use_imm = 1'b1;
      end
      mieu_pkg::F_SLTIU: begin
        entry.op      = mieu_pkg::OP_SLTU;
        entry.use_imm = 1'b1;
      end
      mieu_pkg::F_ANDI: begin
        entry.op      = mieu_pkg::OP_AND;
        entry.use_imm = 1'b1;
        entry.imm     = imm_zext;
      end
      mieu_pkg::F_ORI: begin
        entry.op      = mieu_pkg::OP_OR;
        entry.use_imm = 1'b1;
        entry.imm     = imm_zext;
      end
      mieu_pkg::F_XORI: begin
        entry.op      = mieu_pkg::OP_XOR;
        entry.use_imm = 1'b1;
        entry.imm     = imm_zext;
      end
      mieu_pkg::F_LUI: begin
        entry.op      = mieu_pkg::OP_PASS_B;
        entry.use_imm = 1'b1;
        entry.imm     = imm_upper;
      end
      mieu_pkg::F_J: begin
        entry.op = mieu_pkg::OP_J;
        writes   = 1'b0;
      end
      mieu_pkg::F_JAL: begin
        entry.op   = mieu_pkg::OP_JAL;
        entry.dest = mieu_pkg::LINK_REG;
      end
      default: writes = 1'b0;
    endcase
    // A write to register zero is dropped here, once and for all.
    entry.wr_en = writes && (entry.dest != '0);
  end

endmodule

>>> rtl/core/mieu_queue.sv
// Short register queue between the front end and the execute back end.
`timescale 1ns / 1ps

module mieu_queue (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  mieu_pkg::q_entry_t  push_entry,
  input  logic                pop,
  output mieu_pkg::q_entry_t  head,
  output mieu_pkg::q_status_t status
);

  mieu_pkg::q_entry_t                slot_r [mieu_pkg::QUEUE_DEPTH];
  logic [mieu_pkg::QPTR_W-1:0]       wr_ptr_r, wr_ptr_nxt;
  logic [mieu_pkg::QPTR_W-1:0]       rd_ptr_r, rd_ptr_nxt;
  logic [mieu_pkg::QCNT_W-1:0]       count_r,  count_nxt;

  function automatic logic [mieu_pkg::QPTR_W-1:0] ptr_inc(
    input logic [mieu_pkg::QPTR_W-1:0] p
  );
    if (p == mieu_pkg::QPTR_W'(mieu_pkg::QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return p + 1'b1;
  endfunction

  assign status.empty = (count_r == '0);
  assign status.full  = (count_r == mieu_pkg::QCNT_W'(mieu_pkg::QUEUE_DEPTH));
  assign head         = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ptr_inc(wr_ptr_r) : wr_ptr_r;
    rd_ptr_nxt = pop  ? ptr_inc(rd_ptr_r) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = count_r + 1'b1;
    end else if (pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

endmodule

>>> rtl/core/mieu_back.sv
// Back end: register read, execute, write-back and the result register.
`timescale 1ns / 1ps

module mieu_back (
  input  logic                clk,
  input  logic                rst_n,
  input  mieu_pkg::q_entry_t  head,
  input  mieu_pkg::q_status_t q_status,
  output logic                pop,
  output logic                out_valid,
  input  logic                out_ready,
  output mieu_pkg::result_t   result
);

  localparam int DW = mieu_pkg::DATA_W;

  logic                              x_valid_r, x_valid_nxt;
  mieu_pkg::q_entry_t                x_r;
  logic                              a_vld_r, b_vld_r;
  logic [DW-1:0]                     rdata_a, rdata_b;
  logic [mieu_pkg::NUM_REGS-1:0]     vld_r;
  logic                              lw_valid_r;
  logic [mieu_pkg::REG_IDX_W-1:0]    lw_idx_r;
  logic [DW-1:0]                     lw_val_r;
  logic [DW-1:0]                     pc_r, pc_nxt;
  logic                              out_valid_r, out_valid_nxt;
  mieu_pkg::result_t                 out_r, res;

  logic                              x_adv;
  logic                              issue;
  logic                              we;
  logic [DW-1:0]                     a_op, b_reg, b_op, val;
  logic [mieu_pkg::SHAMT_W-1:0]      sh;

  assign x_adv = x_valid_r && (!out_valid_r || out_ready);
  assign issue = !q_status.empty && (!x_valid_r || x_adv);
  assign pop   = issue;
  assign we    = x_adv && x_r.wr_en;

  mieu_ram #(
    .WIDTH (DW),
    .DEPTH (mieu_pkg::NUM_REGS)
  ) u_regfile (
    .clk     (clk),
    .we      (we),
    .waddr   (x_r.dest),
    .wdata   (val),
    .re      (issue),
    .raddr_a (head.src_a),
    .raddr_b (head.src_b),
    .rdata_a (rdata_a),
    .rdata_b (rdata_b)
  );

  // The last write is always the newest value of its register, so taking it
  // covers a write that lands at the same edge as the read.
  always_comb begin
    if (lw_valid_r && (lw_idx_r == x_r.src_a)) begin
      a_op = lw_val_r;
    end else begin
      a_op = a_vld_r ? rdata_a : '0;
    end
    if (lw_valid_r && (lw_idx_r == x_r.src_b)) begin
      b_reg = lw_val_r;
    end else begin
      b_reg = b_vld_r ? rdata_b : '0;
    end
    b_op = x_r.use_imm ? x_r.imm : b_reg;
    sh   = x_r.use_shamt ? x_r.shamt : b_reg[mieu_pkg::SHAMT_W-1:0];
  end

  always_comb begin
    val    = '0;
    pc_nxt = pc_r;
    case (x_r.op)
      mieu_pkg::OP_ADD:    val = a_op + b_op;
      mieu_pkg::OP_SUB:    val = a_op - b_op;
      mieu_pkg::OP_SLT:    val = {{(DW-1){1'b0}}, ($signed(a_op) < $signed(b_op))};
      mieu_pkg::OP_SLTU:   val = {{(DW-1){1'b0}}, (a_op < b_op)};
      mieu_pkg::OP_AND:    val = a_op & b_op;
      mieu_pkg::OP_OR:     val = a_op | b_op;
      mieu_pkg::OP_XOR:    val = a_op ^ b_op;
      mieu_pkg::OP_NOR:    val = ~(a_op | b_op);
      mieu_pkg::OP_SLL:    val = a_op << sh;
      mieu_pkg::OP_SRL:    val = a_op >> sh;
      mieu_pkg::OP_SRA:    val = $unsigned($signed(a_op) >>> sh);
      mieu_pkg::OP_PASS_B: val = b_op;
      mieu_pkg::OP_J: begin
        pc_nxt = {pc_r[DW-1 -: mieu_pkg::PC_KEEP_W], x_r.target};
      end
      mieu_pkg::OP_JAL: begin
        val    = pc_r;
        pc_nxt = {pc_r[DW-1 -: mieu_pkg::PC_KEEP_W], x_r.target};
      end
      default: val = '0;
    endcase
    res.reg_written   = x_r.wr_en;
    res.written_index = x_r.wr_en ? x_r.dest : '0;
    res.written_value = x_r.wr_en ? val : '0;
    res.pc_value      = pc_nxt;
  end

  always_comb begin
    x_valid_nxt = x_valid_r;
    if (issue) begin
      x_valid_nxt = 1'b1;
    end else if (x_adv) begin
      x_valid_nxt = 1'b0;
    end
    out_valid_nxt = out_valid_r;
    if (x_adv) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_valid_r   <= 1'b0;
      out_valid_r <= 1'b0;
      vld_r       <= '0;
      lw_valid_r  <= 1'b0;
      pc_r        <= '0;
    end else begin
      x_valid_r   <= x_valid_nxt;
      out_valid_r <= out_valid_nxt;
      if (x_adv) begin
        pc_r <= pc_nxt;
      end
      if (we) begin
        vld_r[x_r.dest] <= 1'b1;
        lw_valid_r      <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (issue) begin
      x_r     <= head;
      a_vld_r <= vld_r[head.src_a];
      b_vld_r <= vld_r[head.src_b];
    end
    if (we) begin
      lw_idx_r <= x_r.dest;
      lw_val_r <= val;
    end
    if (x_adv) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign result    = out_r;

endmodule

>>> rtl/core/mips_integer_execute_unit_top.sv
// Top level of the integer execute unit: front end, queue and back end.
//
//   Channel  Direction  Handshake      Carries
//   in_ch    sink       valid / ready  func, register indexes, shift amount,
//                                      immediate, jump target
//   out_ch   source     valid / ready  write flag, written index and value,
//                                      program counter after the instruction
//
// One instruction is taken per cycle and one result is delivered per cycle
// when neither side stalls. A taken instruction is first written into the queue,
// then its operands are read from the register file, whose read data is
// registered, and then it is executed into the result register.
// Reset is synchronous and active low; the register file is cleared at once
// through per-register valid bits, so there is no clearing pass.
// A stall on the result side backs up into the four-entry queue, and in_ch
// keeps taking transfers until that queue is full.
`timescale 1ns / 1ps

module mips_integer_execute_unit_top (
  input  logic       clk,
  input  logic       rst_n,
  mieu_in_if.sink    in_ch,
  mieu_out_if.source out_ch
);

  // Classified instruction handed from the front end into the queue.
  mieu_pkg::q_entry_t  push_entry;
  logic                push;

  // Oldest queued instruction and the queue's fill status.
  mieu_pkg::q_entry_t  head;
  mieu_pkg::q_status_t q_status;
  logic                pop;

  // Result register of the back end.
  mieu_pkg::result_t   result;
  logic                out_valid;

  // The front end only decodes; its ready is simply "queue not full".
  mieu_front u_front (
    .in_ch    (in_ch),
    .q_status (q_status),
    .push     (push),
    .entry    (push_entry)
  );

  // The queue lets the front end keep taking transfers while the back end
  // waits on a stalled result.
  mieu_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .status     (q_status)
  );

  // The back end reads operands, executes, writes back the register file and
  // program counter, and holds the result until the sink takes it.
  mieu_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .q_status  (q_status),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ch.ready),
    .result    (result)
  );

  assign out_ch.valid         = out_valid;
  assign out_ch.reg_written   = result.reg_written;
  assign out_ch.written_index = result.written_index;
  assign out_ch.written_value = result.written_value;
  assign out_ch.pc_value      = result.pc_value;

endmodule

>>> rtl/core/mieu_checker.sv
// Port-level checks of the integer execute unit and their binding.
`timescale 1ns / 1ps

module mieu_checker (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input logic                           reg_written,
  input logic [mieu_pkg::REG_IDX_W-1:0] written_index,
  input logic [mieu_pkg::DATA_W-1:0]    written_value,
  input logic [mieu_pkg::DATA_W-1:0]    pc_value
);

  localparam int CNT_W = $clog2(mieu_pkg::IN_FLIGHT_MAX + 1) + 1;

  logic [CNT_W-1:0] pending_r, pending_nxt;
  logic             in_xfer, out_xfer;

  assign in_xfer  = in_valid && in_ready;
  assign out_xfer = out_valid && out_ready;

  always_comb begin
    pending_nxt = pending_r;
    if (in_xfer && !out_xfer) begin
      pending_nxt = pending_r + 1'b1;
    end else if (out_xfer && !in_xfer) begin
      pending_nxt = pending_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
    end else begin
      pending_r <= pending_nxt;
    end
  end

  // A stalled result stays offered and unchanged.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(reg_written) &&
      $stable(written_index) && $stable(written_value) && $stable(pc_value))
    else $error("result changed or vanished while stalled");

  // No result without an instruction taken for it.
  a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> pending_r != '0)
    else $error("result offered with no instruction outstanding");

  // The queue and the two back-end stages bound what can be in flight.
  a_bound: assert property (@(posedge clk) disable iff (!rst_n)
    pending_r <= CNT_W'(mieu_pkg::IN_FLIGHT_MAX))
    else $error("more instructions in flight than the pipeline holds");

  // A result without a write reports a clean index and value.
  a_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !reg_written |-> written_index == '0 && written_value == '0)
    else $error("non-writing result carries an index or value");

  // Reset empties the result register.
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid straight after reset");

endmodule

bind mips_integer_execute_unit_top mieu_checker u_mieu_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .in_valid      (in_ch.valid),
  .in_ready      (in_ch.ready),
  .out_valid     (out_ch.valid),
  .out_ready     (out_ch.ready),
  .reg_written   (out_ch.reg_written),
  .written_index (out_ch.written_index),
  .written_value (out_ch.written_value),
  .pc_value      (out_ch.pc_value)
);
